### sv/agbkf_pkg.sv
// Shared types and constants of the angle and gyro bias Kalman filter.
`timescale 1ns / 1ps

package agbkf_pkg;

   localparam int IO_W  = 32;
   localparam int CFG_W = 31;
   localparam int IDX_W = 2;
   localparam int DT_W  = 17;

   localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
   localparam logic [IDX_W-1:0] REG_ANGLE_NOISE   = 2'd1;
   localparam logic [IDX_W-1:0] REG_BIAS_NOISE    = 2'd2;
   localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd3;

   localparam logic [DT_W-1:0] DT_RESET = 17'd66;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MSTART,
      ST_MWAIT,
      ST_GAIN,
      ST_DSTART,
      ST_DWAIT,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      MOP_DT_RATE,
      MOP_DT_CBB,
      MOP_DT_S,
      MOP_K0_INNOV,
      MOP_K1_INNOV,
      MOP_K0_P00,
      MOP_K0_P01,
      MOP_K1_P00,
      MOP_K1_P01
   } mop_type;

   typedef struct packed {
      logic    load;
      logic    prep;
      logic    mul_start;
      logic    wb;
      mop_type op;
      logic    gain;
      logic    div_start;
      logic    out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } sts_type;

endpackage

### sv/agbkf_mul.sv
// Sequential rounding and saturating fixed point multiplier built from two half products.
`timescale 1ns / 1ps

module agbkf_mul #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   output logic                done,
   output logic signed [W-1:0] res
);

   localparam int H  = (W + 1) / 2;
   localparam int PW = W + H;
   localparam int AW = 2 * W;
   localparam int RW = AW + 1;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LO   = 3'd1;
   localparam logic [2:0] PH_HI   = 3'd2;
   localparam logic [2:0] PH_ACC  = 3'd3;
   localparam logic [2:0] PH_RND  = 3'd4;

   logic [2:0]        ph_ff;
   logic [W-1:0]      ua_ff;
   logic [W-1:0]      ub_ff;
   logic              neg_ff;
   logic [PW-1:0]     pp_ff;
   logic [AW-1:0]     acc_ff;
   logic signed [W-1:0] res_ff;
   logic              done_ff;

   logic [PW-1:0] pp_lo;
   logic [PW-1:0] pp_hi;
   logic [RW-1:0] rnd;
   logic [RW-1:0] q;
   logic [RW-1:0] lim;
   logic [RW-1:0] qs;
   logic [RW-1:0] qn;

   always_comb begin
      pp_lo = PW'(ua_ff) * PW'(ub_ff[H-1:0]);
      pp_hi = PW'(ua_ff) * PW'(ub_ff[W-1:H]);
      // Round to nearest on the magnitude, ties away from zero.
      rnd   = RW'(acc_ff) + (RW'(1) << (F - 1));
      q     = rnd >> F;
      lim   = neg_ff ? (RW'(1) << (W - 1)) : ((RW'(1) << (W - 1)) - RW'(1));
      qs    = (q > lim) ? lim : q;
      qn    = neg_ff ? (RW'(0) - qs) : qs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (ph_ff)
            PH_IDLE: begin
               if (start) begin
                  ua_ff  <= a[W-1] ? W'(-a) : W'(a);
                  ub_ff  <= b[W-1] ? W'(-b) : W'(b);
                  neg_ff <= a[W-1] ^ b[W-1];
                  ph_ff  <= PH_LO;
               end
            end
            PH_LO: begin
               pp_ff <= pp_lo;
               ph_ff <= PH_HI;
            end
            PH_HI: begin
               acc_ff <= AW'(pp_ff);
               pp_ff  <= pp_hi;
               ph_ff  <= PH_ACC;
            end
            PH_ACC: begin
               acc_ff <= acc_ff + (AW'(pp_ff) << H);
               ph_ff  <= PH_RND;
            end
            PH_RND: begin
               res_ff  <= W'(qn);
               done_ff <= 1'b1;
               ph_ff   <= PH_IDLE;
            end
            default: begin
               ph_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

### sv/agbkf_div.sv
// Two-lane restoring divider that forms both Kalman gains over a shared denominator.
`timescale 1ns / 1ps

module agbkf_div #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] den,
   input  logic signed [W-1:0] num0,
   input  logic signed [W-1:0] num1,
   output logic                done,
   output logic signed [W-1:0] k0,
   output logic signed [W-1:0] k1
);

   localparam int NW = W + F;
   localparam int CW = $clog2(NW + 1);

   logic [W-1:0]        d_ff;
   logic                zero_ff;
   logic [1:0]          neg_ff;
   logic [NW-1:0]       num_ff [2];
   logic [W-1:0]        rem_ff [2];
   logic [CW-1:0]       cnt_ff;
   logic                fin_ff;
   logic                done_ff;
   logic signed [W-1:0] k_ff [2];

   logic [W:0]          rem_sh [2];
   logic [1:0]          ge;
   logic [W-1:0]        rem_nx [2];
   logic [NW-1:0]       lim [2];
   logic [NW-1:0]       qs [2];
   logic [NW-1:0]       qn [2];
   logic [W-1:0]        nmag [2];

   always_comb begin
      nmag[0] = num0[W-1] ? W'(-num0) : W'(num0);
      nmag[1] = num1[W-1] ? W'(-num1) : W'(num1);
      for (int i = 0; i < 2; i++) begin
         rem_sh[i] = {rem_ff[i], num_ff[i][NW-1]};
         ge[i]     = rem_sh[i] >= {1'b0, d_ff};
         rem_nx[i] = ge[i] ? W'(rem_sh[i] - {1'b0, d_ff}) : W'(rem_sh[i]);
         lim[i]    = neg_ff[i] ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
         qs[i]     = (num_ff[i] > lim[i]) ? lim[i] : num_ff[i];
         qn[i]     = neg_ff[i] ? (NW'(0) - qs[i]) : qs[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         fin_ff  <= 1'b0;
         done_ff <= fin_ff;
         if (start) begin
            d_ff      <= den[W-1] ? W'(-den) : W'(den);
            zero_ff   <= (den == '0);
            neg_ff[0] <= num0[W-1] ^ den[W-1];
            neg_ff[1] <= num1[W-1] ^ den[W-1];
            num_ff[0] <= {nmag[0], F'(0)};
            num_ff[1] <= {nmag[1], F'(0)};
            rem_ff[0] <= '0;
            rem_ff[1] <= '0;
            cnt_ff    <= CW'(NW);
         end else if (cnt_ff != '0) begin
            // The numerator register shifts out dividend bits and takes in quotient bits.
            for (int i = 0; i < 2; i++) begin
               rem_ff[i] <= rem_nx[i];
               num_ff[i] <= {num_ff[i][NW-2:0], ge[i]};
            end
            cnt_ff <= cnt_ff - CW'(1);
            fin_ff <= (cnt_ff == CW'(1));
         end
         if (fin_ff) begin
            for (int i = 0; i < 2; i++) begin
               k_ff[i] <= zero_ff ? '0 : W'(qn[i]);
            end
         end
      end
   end

   assign done = done_ff;
   assign k0   = k_ff[0];
   assign k1   = k_ff[1];

endmodule

### sv/agbkf_ctrl.sv
// Controller state machine that sequences predict, gain and update steps.
`timescale 1ns / 1ps

module agbkf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output agbkf_pkg::cmd_type cmd,
   input  agbkf_pkg::sts_type sts
);

   agbkf_pkg::state_type state_ff, state_in;
   agbkf_pkg::mop_type   op_ff, op_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= agbkf_pkg::ST_IDLE;
         op_ff        <= agbkf_pkg::MOP_DT_RATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.op    = op_ff;
      case (state_ff)
         agbkf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = agbkf_pkg::ST_PREP;
            end
         end
         agbkf_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            op_in    = agbkf_pkg::MOP_DT_RATE;
            state_in = agbkf_pkg::ST_MSTART;
         end
         agbkf_pkg::ST_MSTART: begin
            cmd.mul_start = 1'b1;
            state_in      = agbkf_pkg::ST_MWAIT;
         end
         agbkf_pkg::ST_MWAIT: begin
            if (sts.mul_done) begin
               cmd.wb   = 1'b1;
               state_in = agbkf_pkg::ST_MSTART;
               case (op_ff)
                  agbkf_pkg::MOP_DT_RATE:  op_in = agbkf_pkg::MOP_DT_CBB;
                  agbkf_pkg::MOP_DT_CBB:   op_in = agbkf_pkg::MOP_DT_S;
                  agbkf_pkg::MOP_DT_S:     state_in = agbkf_pkg::ST_GAIN;
                  agbkf_pkg::MOP_K0_INNOV: op_in = agbkf_pkg::MOP_K1_INNOV;
                  agbkf_pkg::MOP_K1_INNOV: op_in = agbkf_pkg::MOP_K0_P00;
                  agbkf_pkg::MOP_K0_P00:   op_in = agbkf_pkg::MOP_K0_P01;
                  agbkf_pkg::MOP_K0_P01:   op_in = agbkf_pkg::MOP_K1_P00;
                  agbkf_pkg::MOP_K1_P00:   op_in = agbkf_pkg::MOP_K1_P01;
                  agbkf_pkg::MOP_K1_P01:   state_in = agbkf_pkg::ST_OUT;
                  default:                 state_in = agbkf_pkg::ST_IDLE;
               endcase
            end
         end
         agbkf_pkg::ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = agbkf_pkg::ST_DSTART;
         end
         agbkf_pkg::ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = agbkf_pkg::ST_DWAIT;
         end
         agbkf_pkg::ST_DWAIT: begin
            if (sts.div_done) begin
               op_in    = agbkf_pkg::MOP_K0_INNOV;
               state_in = agbkf_pkg::ST_MSTART;
            end
         end
         agbkf_pkg::ST_OUT: begin
            // Wait until the output register is free before loading it.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = agbkf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = agbkf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/agbkf_dp.sv
// Datapath holding the filter state, configuration, temporaries and arithmetic units.
`timescale 1ns / 1ps

module agbkf_dp #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  agbkf_pkg::cmd_type                     cmd,
   output agbkf_pkg::sts_type                     sts,
   input  logic                                   csr_wr_en,
   input  logic [agbkf_pkg::IDX_W-1:0]            csr_index,
   input  logic [agbkf_pkg::CFG_W-1:0]            csr_wdata,
   input  logic signed [agbkf_pkg::IO_W-1:0]      req_gyro_rate,
   input  logic signed [agbkf_pkg::IO_W-1:0]      req_measured_angle,
   output logic signed [agbkf_pkg::IO_W-1:0]      rsp_angle_estimate,
   output logic signed [agbkf_pkg::IO_W-1:0]      rsp_bias_estimate
);

   localparam int XW = (W > agbkf_pkg::IO_W) ? W : agbkf_pkg::IO_W;
   localparam int SW = W + 2;

   localparam logic signed [W-1:0] VMAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W - 1){1'b0}}};
   localparam logic signed [XW:0]  OMAX = (XW + 1)'(32'sh7FFFFFFF);
   localparam logic signed [XW:0]  OMIN = (XW + 1)'(32'sh80000000);

   function automatic logic signed [W-1:0] sat_s(input logic signed [SW-1:0] v);
      logic signed [W-1:0] r;
      if (v > SW'(VMAX)) begin
         r = VMAX;
      end else if (v < SW'(VMIN)) begin
         r = VMIN;
      end else begin
         r = W'(v);
      end
      return r;
   endfunction

   function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
      return sat_s(SW'(x) + SW'(y));
   endfunction

   function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
      return sat_s(SW'(x) - SW'(y));
   endfunction

   function automatic logic signed [W-1:0] in_sat(
         input logic signed [agbkf_pkg::IO_W-1:0] v);
      logic signed [XW:0] x;
      logic signed [W-1:0] r;
      x = (XW + 1)'(v);
      if (x > (XW + 1)'(VMAX)) begin
         r = VMAX;
      end else if (x < (XW + 1)'(VMIN)) begin
         r = VMIN;
      end else begin
         r = W'(x);
      end
      return r;
   endfunction

   function automatic logic signed [W-1:0] cfg_sat(input logic [agbkf_pkg::CFG_W-1:0] v);
      logic signed [XW:0] x;
      logic signed [W-1:0] r;
      x = $signed((XW + 1)'(v));
      if (x > (XW + 1)'(VMAX)) begin
         r = VMAX;
      end else begin
         r = W'(x);
      end
      return r;
   endfunction

   function automatic logic signed [agbkf_pkg::IO_W-1:0] out_sat(
         input logic signed [W-1:0] v);
      logic signed [XW:0] x;
      logic signed [agbkf_pkg::IO_W-1:0] r;
      x = (XW + 1)'(v);
      if (x > OMAX) begin
         r = OMAX[agbkf_pkg::IO_W-1:0];
      end else if (x < OMIN) begin
         r = OMIN[agbkf_pkg::IO_W-1:0];
      end else begin
         r = x[agbkf_pkg::IO_W-1:0];
      end
      return r;
   endfunction

   logic [agbkf_pkg::DT_W-1:0]  sp_ff;
   logic [agbkf_pkg::CFG_W-1:0] qa_ff;
   logic [agbkf_pkg::CFG_W-1:0] qb_ff;
   logic [agbkf_pkg::CFG_W-1:0] r_ff;

   logic signed [W-1:0] angle_ff, bias_ff, caa_ff, cab_ff, cba_ff, cbb_ff;
   logic signed [W-1:0] rate_ff, z_ff, d1_ff, sab_ff, angp_ff, s_ff;
   logic signed [W-1:0] p00_ff, p01_ff, p10_ff, p11_ff, den_ff, innov_ff;
   logic signed [agbkf_pkg::IO_W-1:0] out_angle_ff, out_bias_ff;

   logic signed [W-1:0] dt, qa, qb, rr;
   logic signed [W-1:0] mul_a, mul_b, mres, k0, k1;
   logic                mul_done, div_done;

   assign dt = $signed(W'(sp_ff));
   assign qa = cfg_sat(qa_ff);
   assign qb = cfg_sat(qb_ff);
   assign rr = cfg_sat(r_ff);

   always_comb begin
      case (cmd.op)
         agbkf_pkg::MOP_DT_RATE:  begin mul_a = dt; mul_b = d1_ff;    end
         agbkf_pkg::MOP_DT_CBB:   begin mul_a = dt; mul_b = cbb_ff;   end
         agbkf_pkg::MOP_DT_S:     begin mul_a = dt; mul_b = s_ff;     end
         agbkf_pkg::MOP_K0_INNOV: begin mul_a = k0; mul_b = innov_ff; end
         agbkf_pkg::MOP_K1_INNOV: begin mul_a = k1; mul_b = innov_ff; end
         agbkf_pkg::MOP_K0_P00:   begin mul_a = k0; mul_b = p00_ff;   end
         agbkf_pkg::MOP_K0_P01:   begin mul_a = k0; mul_b = p01_ff;   end
         agbkf_pkg::MOP_K1_P00:   begin mul_a = k1; mul_b = p00_ff;   end
         agbkf_pkg::MOP_K1_P01:   begin mul_a = k1; mul_b = p01_ff;   end
         default:                 begin mul_a = '0; mul_b = '0;       end
      endcase
   end

   agbkf_mul #(.W(W), .F(F)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .res   (mres)
   );

   agbkf_div #(.W(W), .F(F)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .den   (den_ff),
      .num0  (p00_ff),
      .num1  (p10_ff),
      .done  (div_done),
      .k0    (k0),
      .k1    (k1)
   );

   assign sts.mul_done = mul_done;
   assign sts.div_done = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= agbkf_pkg::DT_RESET;
         qa_ff    <= '0;
         qb_ff    <= '0;
         r_ff     <= '0;
         angle_ff <= '0;
         bias_ff  <= '0;
         caa_ff   <= W'(1) << F;
         cab_ff   <= '0;
         cba_ff   <= '0;
         cbb_ff   <= W'(1) << F;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               agbkf_pkg::REG_SAMPLE_PERIOD: sp_ff <= csr_wdata[agbkf_pkg::DT_W-1:0];
               agbkf_pkg::REG_ANGLE_NOISE:   qa_ff <= csr_wdata;
               agbkf_pkg::REG_BIAS_NOISE:    qb_ff <= csr_wdata;
               agbkf_pkg::REG_MEASURE_NOISE: r_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            rate_ff <= in_sat(req_gyro_rate);
            z_ff    <= in_sat(req_measured_angle);
         end
         if (cmd.prep) begin
            d1_ff  <= sub_s(rate_ff, bias_ff);
            sab_ff <= add_s(cab_ff, cba_ff);
            p11_ff <= add_s(cbb_ff, qb);
         end
         if (cmd.wb) begin
            case (cmd.op)
               agbkf_pkg::MOP_DT_RATE: angp_ff <= add_s(angle_ff, mres);
               agbkf_pkg::MOP_DT_CBB: begin
                  s_ff   <= sub_s(mres, sab_ff);
                  p01_ff <= sub_s(cab_ff, mres);
                  p10_ff <= sub_s(cba_ff, mres);
               end
               // The three terms are summed at full width and limited once.
               agbkf_pkg::MOP_DT_S:     p00_ff <= sat_s(SW'(caa_ff) + SW'(mres) + SW'(qa));
               agbkf_pkg::MOP_K0_INNOV: angle_ff <= add_s(angp_ff, mres);
               agbkf_pkg::MOP_K1_INNOV: bias_ff <= add_s(bias_ff, mres);
               agbkf_pkg::MOP_K0_P00:   caa_ff <= sub_s(p00_ff, mres);
               agbkf_pkg::MOP_K0_P01:   cab_ff <= sub_s(p01_ff, mres);
               agbkf_pkg::MOP_K1_P00:   cba_ff <= sub_s(p10_ff, mres);
               agbkf_pkg::MOP_K1_P01:   cbb_ff <= sub_s(p11_ff, mres);
               default: ;
            endcase
         end
         if (cmd.gain) begin
            den_ff   <= add_s(p00_ff, rr);
            innov_ff <= sub_s(z_ff, angp_ff);
         end
         if (cmd.out_load) begin
            out_angle_ff <= out_sat(angle_ff);
            out_bias_ff  <= out_sat(bias_ff);
         end
      end
   end

   assign rsp_angle_estimate = out_angle_ff;
   assign rsp_bias_estimate  = out_bias_ff;

endmodule

### sv/angle_gyro_bias_kalman_filter_unit.sv
// Usage: req_valid/req_ready carry one request of a gyro rate and a measured angle,
// each signed Q16.16. rsp_valid/rsp_ready return the updated angle and gyro bias.
// csr_wr_en writes csr_wdata into the register csr_index selects: 0 sample period,
// 1 angle process noise, 2 bias process noise, 3 measurement noise. Write them
// only while no request is in flight.
// One request is processed at a time. Nine products go through one shared
// multiplier. The two gains come from a two-lane divider that produces one
// quotient bit per lane per cycle.
// The result sits in an output register, so a new request is taken while it waits.
// If the receiver stalls, the next result is held back until that register frees.
// Synchronous reset sets the angle and bias to zero and the covariance to identity.
// It also loads the register defaults and discards any request in progress.
`timescale 1ns / 1ps

module angle_gyro_bias_kalman_filter_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [agbkf_pkg::IO_W-1:0]    req_gyro_rate,
   input  logic signed [agbkf_pkg::IO_W-1:0]    req_measured_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [agbkf_pkg::IO_W-1:0]    rsp_angle_estimate,
   output logic signed [agbkf_pkg::IO_W-1:0]    rsp_bias_estimate,
   input  logic                                 csr_wr_en,
   input  logic [agbkf_pkg::IDX_W-1:0]          csr_index,
   input  logic [agbkf_pkg::CFG_W-1:0]          csr_wdata
);

   agbkf_pkg::cmd_type cmd;
   agbkf_pkg::sts_type sts;

   agbkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   agbkf_dp #(.W(DATA_WIDTH), .F(FRAC_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_gyro_rate      (req_gyro_rate),
      .req_measured_angle (req_measured_angle),
      .rsp_angle_estimate (rsp_angle_estimate),
      .rsp_bias_estimate  (rsp_bias_estimate)
   );

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while a response was pending");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted while one is in progress");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sts.mul_done && sts.div_done))
      else $error("multiplier and divider finished in the same cycle");
`endif

endmodule
